@@ rtl/ssvo_pkg.sv @@
`timescale 1ns / 1ps

package ssvo_pkg;

  // Sample width of the mix words and of the voice sample.
  localparam int unsigned SAMPLE_BITS = 24;

  // Gains are Q24; 1.0 needs a 25th bit.
  localparam int unsigned GAIN_W = 25;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 25'h100_0000;

  // pi/5 in Q32.
  localparam logic [31:0] PI5_Q32 = 32'd2698607541;

  // ceil(2^33 / 3): x * RECIP3 >> 33 equals x / 3 for any 32-bit x.
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
  localparam int unsigned RECIP3_SHIFT = 33;

  // The divisor 6 * 2^(33 - SAMPLE_BITS) is split into 3 and a power of two.
  localparam int unsigned DIV_SHIFT = 34 - SAMPLE_BITS;
  localparam logic [33:0] DEN_HALF = 34'(3 * (2 ** (33 - SAMPLE_BITS)));

  // Register reset values.
  localparam logic [GAIN_W-1:0] ATTACK_STEP_RST  = 25'd174763;
  localparam logic [GAIN_W-1:0] RELEASE_STEP_RST = 25'd699;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP   = 2'd0,
    CFG_ATTACK_STEP  = 2'd1,
    CFG_RELEASE_STEP = 2'd2
  } cfg_index_e;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                          note_start;
    logic                          note_gate;
    logic signed [SAMPLE_BITS-1:0] mix_in_left;
    logic signed [SAMPLE_BITS-1:0] mix_in_right;
    logic                          end_of_block;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mix_out_left;
    logic signed [SAMPLE_BITS-1:0] mix_out_right;
    logic                          voice_active;
    logic                          block_done;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_TRI,
    ST_SUM,
    ST_MUL_DIV,
    ST_QUO,
    ST_MUL_ATK,
    ST_RND_ATK,
    ST_MUL_REL,
    ST_RND_REL,
    ST_MIX
  } back_state_e;

endpackage

@@ rtl/ssvo_front.sv @@
`timescale 1ns / 1ps

module ssvo_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ssvo_pkg::in_t   in_data_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output ssvo_pkg::in_t   q_item_o
);

  ssvo_pkg::in_t                          entry_q [ssvo_pkg::QUEUE_DEPTH];
  logic [ssvo_pkg::QUEUE_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ssvo_pkg::QUEUE_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ssvo_pkg::QUEUE_CNT_W-1:0]       count_q, count_d;
  logic                                   push, pop;

  always_comb begin
    in_ready_o = (count_q != ssvo_pkg::QUEUE_CNT_W'(ssvo_pkg::QUEUE_DEPTH));
    q_valid_o  = (count_q != '0);
    q_item_o   = entry_q[rd_ptr_q];
    push       = in_valid_i && in_ready_o;
    pop        = q_valid_o && q_ready_i;
    wr_ptr_d   = push ? wr_ptr_q + ssvo_pkg::QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d   = pop ? rd_ptr_q + ssvo_pkg::QUEUE_PTR_W'(1) : rd_ptr_q;
    count_d    = count_q;
    if (push && !pop) begin
      count_d = count_q + ssvo_pkg::QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - ssvo_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

@@ rtl/ssvo_back.sv @@
`timescale 1ns / 1ps

module ssvo_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  ssvo_pkg::in_t                   q_item_i,
  input  logic [31:0]                     phase_step_i,
  input  logic [ssvo_pkg::GAIN_W-1:0]     attack_step_i,
  input  logic [ssvo_pkg::GAIN_W-1:0]     release_step_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ssvo_pkg::out_t                  out_data_o
);

  localparam int unsigned SB = ssvo_pkg::SAMPLE_BITS;
  localparam int unsigned GW = ssvo_pkg::GAIN_W;
  localparam logic signed [SB:0] SAT_MAX = {2'b00, {(SB-1){1'b1}}};
  localparam logic signed [SB:0] SAT_MIN = {2'b11, {(SB-1){1'b0}}};

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                  input logic signed [SB:0]   v);
    logic signed [SB:0] s;
    s = {a[SB-1], a} + v;
    if (s > SAT_MAX) begin
      s = SAT_MAX;
    end else if (s < SAT_MIN) begin
      s = SAT_MIN;
    end
    return s[SB-1:0];
  endfunction

  ssvo_pkg::back_state_e state_q, state_d;

  // Voice state.
  logic [31:0]  phase_q, phase_d;
  logic [GW-1:0] atk_q, atk_d;
  logic [GW-1:0] rel_q, rel_d;
  logic          snd_q, snd_d;

  // Per-word working registers.
  ssvo_pkg::in_t   item_q;
  logic [32:0]     t_q;
  logic            neg_q, add_q, active_q;
  logic            atk_use_q, rel_use_q;
  logic [GW-1:0]   atk_g_q, rel_g_q;
  logic [63:0]     prod_q;
  logic [31:0]     x_q;
  logic [SB-2:0]   vmag_q;
  logic            out_valid_q;
  ssvo_pkg::out_t  out_data_q;

  // Values formed while a word is taken from the queue.
  logic            pop, start, gate, run, rel_done;
  logic [31:0]     ph_s;
  logic [GW-1:0]   atk_s, rel_s, atk_sat, rel_sat;
  logic [GW:0]     atk_sum, rel_sum;
  logic [32:0]     t_d;
  logic            add_d, atk_use_d, rel_use_d;

  // Shared datapath.
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p, rnd, gain_rnd;
  logic [31:0]     tri_v;
  logic [33:0]     mag, sum_sh;
  logic [SB-2:0]   vmag_d;
  logic signed [SB:0] vs;
  logic            out_load;
  ssvo_pkg::out_t  out_d;

  always_comb begin
    pop   = (state_q == ssvo_pkg::ST_IDLE) && q_valid_i;
    start = q_item_i.note_start;
    gate  = q_item_i.note_gate;
    ph_s  = start ? '0 : phase_q;
    atk_s = start ? '0 : atk_q;
    rel_s = start ? '0 : rel_q;
    run   = (start || snd_q) && (gate || (atk_s != '0));
    rel_done = !gate && (rel_s >= ssvo_pkg::GAIN_ONE);
    add_d = run && !rel_done;

    atk_sum = {1'b0, atk_s} + {1'b0, attack_step_i};
    atk_sat = (atk_sum > {1'b0, ssvo_pkg::GAIN_ONE}) ? ssvo_pkg::GAIN_ONE : atk_sum[GW-1:0];
    rel_sum = {1'b0, rel_s} + {1'b0, release_step_i};
    rel_sat = (rel_sum > {1'b0, ssvo_pkg::GAIN_ONE}) ? ssvo_pkg::GAIN_ONE : rel_sum[GW-1:0];

    atk_use_d = atk_s < ssvo_pkg::GAIN_ONE;
    rel_use_d = !gate && (rel_s < ssvo_pkg::GAIN_ONE);

    // Triangle position: twice the distance of the phase from the quarter-cycle peak.
    // Past three quarters the distance wraps through zero, so 32-bit wrapping
    // arithmetic gives it directly.
    if (ph_s < 32'hC000_0000) begin
      if (ph_s >= 32'h4000_0000) begin
        t_d = {ph_s - 32'h4000_0000, 1'b0};
      end else begin
        t_d = {32'h4000_0000 - ph_s, 1'b0};
      end
    end else begin
      t_d = {32'h4000_0000 - ph_s, 1'b0};
    end

    phase_d = phase_q;
    atk_d   = atk_q;
    rel_d   = rel_q;
    snd_d   = snd_q;
    if (pop) begin
      phase_d = ph_s;
      atk_d   = atk_s;
      rel_d   = rel_s;
      snd_d   = start || snd_q;
      if (run) begin
        phase_d = ph_s + phase_step_i;
        if (atk_use_d) begin
          atk_d = atk_sat;
        end
        if (!gate) begin
          if (rel_use_d) begin
            rel_d = rel_sat;
          end else begin
            snd_d = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    mul_a = t_q[31:0];
    mul_b = ssvo_pkg::PI5_Q32;
    case (state_q)
      ssvo_pkg::ST_MUL_DIV: begin
        mul_a = x_q;
        mul_b = ssvo_pkg::RECIP3;
      end
      ssvo_pkg::ST_MUL_ATK: begin
        mul_a = {{(33-SB){1'b0}}, vmag_q};
        mul_b = {{(32-GW){1'b0}}, atk_g_q};
      end
      ssvo_pkg::ST_MUL_REL: begin
        mul_a = {{(33-SB){1'b0}}, vmag_q};
        mul_b = {{(32-GW){1'b0}}, rel_g_q};
      end
      default: begin
        mul_a = t_q[31:0];
        mul_b = ssvo_pkg::PI5_Q32;
      end
    endcase
    mul_p = mul_a * mul_b;

    // The full-cycle triangle value of 2^32 only shows up as t_q[32].
    rnd      = prod_q + 64'h8000_0000;
    gain_rnd = prod_q + 64'h80_0000;
    tri_v  = t_q[32] ? ssvo_pkg::PI5_Q32 : rnd[63:32];
    mag    = neg_q ? (34'h1_0000_0000 + {2'b00, tri_v}) : (34'h1_0000_0000 - {2'b00, tri_v});
    sum_sh = (mag + ssvo_pkg::DEN_HALF) >> ssvo_pkg::DIV_SHIFT;
    vmag_d = prod_q[ssvo_pkg::RECIP3_SHIFT +: (SB-1)];

    vs = neg_q ? -$signed({2'b00, vmag_q}) : $signed({2'b00, vmag_q});
    if (!add_q) begin
      vs = '0;
    end
    out_d.mix_out_left  = sat_add(item_q.mix_in_left, vs);
    out_d.mix_out_right = sat_add(item_q.mix_in_right, vs);
    out_d.voice_active  = active_q;
    out_d.block_done    = item_q.end_of_block;
  end

  always_comb begin
    state_d   = state_q;
    q_ready_o = (state_q == ssvo_pkg::ST_IDLE);
    out_load  = 1'b0;
    case (state_q)
      ssvo_pkg::ST_IDLE: begin
        if (pop) begin
          state_d = add_d ? ssvo_pkg::ST_MUL_TRI : ssvo_pkg::ST_MIX;
        end
      end
      ssvo_pkg::ST_MUL_TRI: state_d = ssvo_pkg::ST_SUM;
      ssvo_pkg::ST_SUM:     state_d = ssvo_pkg::ST_MUL_DIV;
      ssvo_pkg::ST_MUL_DIV: state_d = ssvo_pkg::ST_QUO;
      ssvo_pkg::ST_QUO: begin
        if (atk_use_q) begin
          state_d = ssvo_pkg::ST_MUL_ATK;
        end else if (rel_use_q) begin
          state_d = ssvo_pkg::ST_MUL_REL;
        end else begin
          state_d = ssvo_pkg::ST_MIX;
        end
      end
      ssvo_pkg::ST_MUL_ATK: state_d = ssvo_pkg::ST_RND_ATK;
      ssvo_pkg::ST_RND_ATK: state_d = rel_use_q ? ssvo_pkg::ST_MUL_REL : ssvo_pkg::ST_MIX;
      ssvo_pkg::ST_MUL_REL: state_d = ssvo_pkg::ST_RND_REL;
      ssvo_pkg::ST_RND_REL: state_d = ssvo_pkg::ST_MIX;
      ssvo_pkg::ST_MIX: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ssvo_pkg::ST_IDLE;
        end
      end
      default: state_d = ssvo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssvo_pkg::ST_IDLE;
      phase_q     <= '0;
      atk_q       <= '0;
      rel_q       <= '0;
      snd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      atk_q   <= atk_d;
      rel_q   <= rel_d;
      snd_q   <= snd_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q    <= q_item_i;
      t_q       <= t_d;
      neg_q     <= !(ph_s <= 32'h8000_0000);
      add_q     <= add_d;
      active_q  <= snd_d;
      atk_use_q <= atk_use_d;
      rel_use_q <= rel_use_d;
      atk_g_q   <= atk_s;
      rel_g_q   <= ssvo_pkg::GAIN_ONE - rel_s;
    end
    case (state_q)
      ssvo_pkg::ST_MUL_TRI,
      ssvo_pkg::ST_MUL_DIV,
      ssvo_pkg::ST_MUL_ATK,
      ssvo_pkg::ST_MUL_REL: prod_q <= mul_p;
      ssvo_pkg::ST_SUM:     x_q    <= sum_sh[31:0];
      ssvo_pkg::ST_QUO:     vmag_q <= vmag_d;
      ssvo_pkg::ST_RND_ATK,
      ssvo_pkg::ST_RND_REL: vmag_q <= gain_rnd[24 +: (SB-1)];
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) atk_q <= ssvo_pkg::GAIN_ONE)
    else $error("attack level above unity");

  assert property (@(posedge clk_i) disable iff (!rst_ni) rel_q <= ssvo_pkg::GAIN_ONE)
    else $error("release level above unity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_valid_q) |-> $past(state_q) == ssvo_pkg::ST_MIX)
    else $error("result word raised outside the mix step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop && !add_d) |=> state_q == ssvo_pkg::ST_MIX)
    else $error("silent word did not go straight to the mix step");

endmodule

@@ rtl/shaped_square_voice_oscillator_core.sv @@
`timescale 1ns / 1ps

// Single-voice shaped-square oscillator that adds its sample into a stereo mix stream.
// Each input word is one audio frame; each frame yields exactly one output word. Input
// words land in a two-entry queue, so up to two words are taken while the engine works
// or a finished word waits at the output; beyond that the input stalls. The engine
// handles one frame at a time through one shared 32x32 multiplier: a voiced frame runs
// the triangle multiply, sum, divide multiply and quotient steps, then multiply and round
// steps for the attack gain and for the release gain where each applies; a silent frame
// passes the mix through unchanged and goes straight to the mix step, which waits for the
// previous word to leave the output. Configuration registers (phase step, attack step,
// release step) are written through their own port, which is always ready.

module shaped_square_voice_oscillator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ssvo_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ssvo_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ssvo_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  logic [31:0]                   phase_step_q;
  logic [ssvo_pkg::GAIN_W-1:0]   attack_step_q;
  logic [ssvo_pkg::GAIN_W-1:0]   release_step_q;
  logic                          q_valid, q_ready;
  ssvo_pkg::in_t                 q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= '0;
      attack_step_q  <= ssvo_pkg::ATTACK_STEP_RST;
      release_step_q <= ssvo_pkg::RELEASE_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ssvo_pkg::CFG_PHASE_STEP:   phase_step_q   <= cfg_data_i;
        ssvo_pkg::CFG_ATTACK_STEP:  attack_step_q  <= cfg_data_i[ssvo_pkg::GAIN_W-1:0];
        ssvo_pkg::CFG_RELEASE_STEP: release_step_q <= cfg_data_i[ssvo_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  ssvo_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  ssvo_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .q_item_i       (q_item),
    .phase_step_i   (phase_step_q),
    .attack_step_i  (attack_step_q),
    .release_step_i (release_step_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule
